FILE: src/smpc_pkg.sv
// ----------------------------------------------------------------------------
// smpc_pkg
// Shared types and constants of the shadow memory poison checker.
// ----------------------------------------------------------------------------
package smpc_pkg;

  localparam int unsigned SHADOW_DEPTH = 4096;
  localparam int unsigned GRAN_BYTES   = 8;
  localparam int unsigned GRAN_AW      = $clog2(SHADOW_DEPTH);
  localparam int unsigned WINDOW_BYTES = SHADOW_DEPTH * GRAN_BYTES;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFF_W    = 3;
  localparam int unsigned SUM_W    = LEN_W + 1;

  localparam logic [GRAN_AW-1:0] LAST_GRAN = GRAN_AW'(SHADOW_DEPTH - 1);

  typedef enum logic [KIND_W-1:0] {
    K_HOOK_CHECK  = 3'd0,
    K_CHECK       = 3'd1,
    K_POISON      = 3'd2,
    K_USER_POISON = 3'd3,
    K_UNPOISON    = 3'd4,
    K_SWAP        = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_DRAIN,
    ST_WALK_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic clear;
    logic adv;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_rd;
    logic walk_wr;
    logic at_last;
  } dp_sts_t;

endpackage

FILE: src/smpc_if.sv
// ----------------------------------------------------------------------------
// smpc_if
// Request, response and configuration channels of the poison checker.
// ----------------------------------------------------------------------------
interface smpc_req_if;
  import smpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   addr;
  logic [LEN_W-1:0]    length;
  logic [BYTE_W-1:0]   fill_byte;
  logic                new_disabled;

  modport source (output valid, kind, addr, length, fill_byte, new_disabled,
                  input ready);
  modport sink (input valid, kind, addr, length, fill_byte, new_disabled,
                output ready);
endinterface

interface smpc_rsp_if;
  logic valid;
  logic ready;
  logic poisoned;
  logic applied;
  logic old_disabled;
  logic range_error;

  modport source (output valid, poisoned, applied, old_disabled, range_error,
                  input ready);
  modport sink (input valid, poisoned, applied, old_disabled, range_error,
                output ready);
endinterface

interface smpc_cfg_if;
  import smpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: src/smpc_dp.sv
// ----------------------------------------------------------------------------
// smpc_dp
// Datapath: shadow store, granule walker, request decode and result register.
// ----------------------------------------------------------------------------
module smpc_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  smpc_pkg::dp_cmd_t         cmd,
  output smpc_pkg::dp_sts_t         sts,
  input  logic [smpc_pkg::KIND_W-1:0] kind,
  input  logic [smpc_pkg::ADDR_W-1:0] addr,
  input  logic [smpc_pkg::LEN_W-1:0]  length,
  input  logic [smpc_pkg::BYTE_W-1:0] fill_byte,
  input  logic                      new_disabled,
  input  logic                      cfg_we,
  input  logic [smpc_pkg::BYTE_W-1:0] cfg_data,
  output logic                      poisoned,
  output logic                      applied,
  output logic                      old_disabled,
  output logic                      range_error
);
  import smpc_pkg::*;

  logic [BYTE_W-1:0]  mem [SHADOW_DEPTH];
  logic [BYTE_W-1:0]  rdata;

  logic [GRAN_AW-1:0] cur;
  logic [GRAN_AW-1:0] last;
  logic [GRAN_AW-1:0] first;
  logic [GRAN_AW-1:0] tail;
  logic [OFF_W-1:0]   off;
  logic [3:0]         e_last;
  logic               tail_part;
  logic [BYTE_W-1:0]  pb_eff;
  logic               is_poison;
  logic               disabled;
  logic [BYTE_W-1:0]  user_poison_value;

  logic               rd_pend;
  logic               rd_part;
  logic [3:0]         rd_e;

  logic               res_poisoned;
  logic               res_applied;
  logic               res_old;
  logic               res_rerr;

  // Decode of the request on the input port.
  kind_t              k;
  logic               known;
  logic               is_chk;
  logic               is_pk;
  logic               dis_hook;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   endm1;
  logic [SUM_W-1:0]   pend;
  logic [SUM_W-1:0]   g0_w;
  logic               oow;
  logic               act;
  logic               empty;
  logic [BYTE_W-1:0]  wdata;
  logic [3:0]         e_cur;
  logic               part_cur;
  logic               bad;

  always_comb begin
    k        = kind_t'(kind);
    known    = 1'b1;
    is_chk   = 1'b0;
    is_pk    = 1'b0;
    case (k)
      K_HOOK_CHECK, K_CHECK:    is_chk = 1'b1;
      K_POISON, K_USER_POISON:  is_pk = 1'b1;
      K_UNPOISON:               known = 1'b1;
      default:                  known = 1'b0;
    endcase
    dis_hook = (k == K_HOOK_CHECK) && disabled;
    sum      = {2'b00, addr} + {1'b0, length};
    endm1    = sum - SUM_W'(1);
    pend     = sum >> 3;
    g0_w     = SUM_W'(addr >> 3);
    oow      = {{(32-SUM_W){1'b0}}, sum} > WINDOW_BYTES;
    act      = known && !dis_hook && !oow && (length != '0);
    empty    = (pend == g0_w);
    sts.walk_rd = act && is_chk;
    sts.walk_wr = act && ((k == K_UNPOISON) || (is_pk && !empty));
    sts.at_last = (cur == last);
  end

  // Per-granule access window: an unaligned head and an unaligned tail granule use the
  // partial rule, every other granule must be fully valid.
  always_comb begin
    e_cur    = (cur == tail) ? e_last : 4'd8;
    part_cur = ((cur == first) && (off != '0)) || ((cur == tail) && tail_part);
    if (rd_part) begin
      bad = (rdata != '0) &&
            ($signed({5'd0, rd_e}) > $signed({rdata[BYTE_W-1], rdata}));
    end else begin
      bad = (rdata != '0);
    end
    if (cmd.clear) begin
      wdata = '0;
    end else if (is_poison && (cur == first) && (off != '0)) begin
      wdata = BYTE_W'(off);
    end else begin
      wdata = pb_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cur] <= wdata;
    end
    rdata <= mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur               <= '0;
      last              <= LAST_GRAN;
      disabled          <= 1'b0;
      user_poison_value <= 8'd247;
      rd_pend           <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
      if (cfg_we) begin
        user_poison_value <= cfg_data;
      end
      if (cmd.load) begin
        cur <= GRAN_AW'(addr >> 3);
        if (is_pk) begin
          last <= GRAN_AW'(pend - SUM_W'(1));
        end else begin
          last <= GRAN_AW'(endm1 >> 3);
        end
        if (k == K_SWAP) begin
          disabled <= new_disabled;
        end
      end else if (cmd.adv) begin
        cur <= cur + GRAN_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_part <= part_cur;
      rd_e    <= e_cur;
    end
    if (cmd.load) begin
      first        <= GRAN_AW'(addr >> 3);
      tail         <= GRAN_AW'(endm1 >> 3);
      off          <= addr[OFF_W-1:0];
      e_last       <= {1'b0, endm1[OFF_W-1:0]} + 4'd1;
      tail_part    <= (sum[OFF_W-1:0] != '0);
      is_poison    <= is_pk;
      case (k)
        K_POISON:      pb_eff <= fill_byte;
        K_USER_POISON: pb_eff <= user_poison_value;
        default:       pb_eff <= '0;
      endcase
      res_poisoned <= 1'b0;
      res_applied  <= (is_pk && act && ((addr[OFF_W-1:0] == '0) || !empty)) ||
                      ((k == K_UNPOISON) && !oow);
      res_old      <= (k == K_SWAP) && disabled;
      res_rerr     <= known && !dis_hook && oow;
    end else if (rd_pend && bad) begin
      res_poisoned <= 1'b1;
    end
    if (cmd.publish) begin
      poisoned     <= res_poisoned;
      applied      <= res_applied;
      old_disabled <= res_old;
      range_error  <= res_rerr;
    end
  end

  a_wr_in_span: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && !cmd.clear) |-> (cur >= first) && (cur <= last))
    else $error("shadow write outside the request span");

  a_rd_in_span: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (cur >= first) && (cur <= tail))
    else $error("shadow read outside the request span");

  a_flag_swap: assert property (@(posedge clk) disable iff (rst)
    !$stable(disabled) |-> $past(cmd.load && (kind == K_SWAP)))
    else $error("disabled flag changed without a swap request");

endmodule

FILE: src/smpc_ctrl.sv
// ----------------------------------------------------------------------------
// smpc_ctrl
// Controller: clearing pass, granule walk sequencing and response handshake.
// ----------------------------------------------------------------------------
module smpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output smpc_pkg::dp_cmd_t cmd,
  input  smpc_pkg::dp_sts_t sts
);
  import smpc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd            = '0;
    req_ready      = 1'b0;
    state_next     = state;
    out_valid_next = out_valid && !rsp_ready;
    case (state)
      ST_CLEAR: begin
        cmd.wr    = 1'b1;
        cmd.clear = 1'b1;
        if (sts.at_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          if (sts.walk_rd) begin
            state_next = ST_WALK_RD;
          end else if (sts.walk_wr) begin
            state_next = ST_WALK_WR;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_WALK_RD: begin
        cmd.rd = 1'b1;
        if (sts.at_last) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      // The last granule's read data is evaluated here.
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_WALK_WR: begin
        cmd.wr = 1'b1;
        if (sts.at_last) begin
          state_next = ST_FIN;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid || rsp_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid = out_valid;

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && sts.at_last) |=> (state == ST_IDLE))
    else $error("clearing pass did not end at the last granule");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || rsp_ready))
    else $error("response overwritten before it was taken");

endmodule

FILE: src/shadow_memory_poison_checker.sv
// A check reads its granules in turn, evaluates the last read data and then
// publishes; poison and unpoison write their granules and then publish; a request
// with no granules to walk publishes directly. One request at a time is taken,
// and the shadow store's single port walks one granule per cycle.
// Reset: the flag and the register return to their reset values, then a
// clearing pass zeroes the store while no request is accepted.
// ----------------------------------------------------------------------------
// shadow_memory_poison_checker
// Top level: shadow byte store with check, poison, unpoison and swap requests.
// ----------------------------------------------------------------------------
module shadow_memory_poison_checker (
  input  logic     clk,
  input  logic     rst,
  smpc_req_if.sink   req,
  smpc_rsp_if.source rsp,
  smpc_cfg_if.sink   cfg
);
  import smpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    rsp_valid;
  logic    req_ready;

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  smpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  smpc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (req.kind),
    .addr         (req.addr),
    .length       (req.length),
    .fill_byte    (req.fill_byte),
    .new_disabled (req.new_disabled),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .poisoned     (rsp.poisoned),
    .applied      (rsp.applied),
    .old_disabled (rsp.old_disabled),
    .range_error  (rsp.range_error)
  );

endmodule

FILE: tb/sv/smpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_checker
// Watches the request, response and configuration channels of the shadow
// memory poison checker. It keeps its own copy of the shadow bytes, the
// disabled flag and the user poison value, predicts the outcome of every
// accepted request and compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module smpc_checker (
  input  logic       clk,
  input  logic       rst,
  smpc_req_if        req,
  smpc_rsp_if        rsp,
  smpc_cfg_if        cfg,
  output int         fail_count,
  output int         pending
);
  import smpc_pkg::*;

  localparam int unsigned GRAN_MASK   = GRAN_BYTES - 1;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic poisoned;
    logic applied;
    logic old_disabled;
    logic range_error;
  } outcome_t;

  logic [BYTE_W-1:0] shadow_mirror [SHADOW_DEPTH];
  logic              disabled_mirror;
  logic [BYTE_W-1:0] user_poison_mirror;
  outcome_t          awaited_outcomes [$];
  int                mismatches;
  int                rsp_seen;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: response %0d: %s", $time, rsp_seen, what);
  endtask

  task automatic compare_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
  endtask

  // A granule counts as short for an access when its shadow byte is nonzero
  // and the access ends beyond the count that byte holds, read as signed.
  function automatic bit granule_short(int unsigned g, int unsigned off, int unsigned sz);
    int k;
    k = int'($signed(shadow_mirror[g % SHADOW_DEPTH]));
    return (k != 0) && (int'(off + sz) > k);
  endfunction

  function automatic bit region_poisoned(int unsigned start, int unsigned n);
    int unsigned pos;
    int unsigned stop;
    int unsigned tail;
    int unsigned head;
    if (n == 0) return 1'b0;
    pos  = start;
    stop = start + n;
    tail = stop & ~GRAN_MASK;
    if ((pos & GRAN_MASK) != 0) begin
      head = GRAN_BYTES - (pos & GRAN_MASK);
      if (n <= head) return granule_short(pos / GRAN_BYTES, pos & GRAN_MASK, n);
      if (granule_short(pos / GRAN_BYTES, pos & GRAN_MASK, head)) return 1'b1;
      pos = pos - (pos & GRAN_MASK) + GRAN_BYTES;
    end
    while (pos < tail) begin
      if (shadow_mirror[(pos / GRAN_BYTES) % SHADOW_DEPTH] != '0) return 1'b1;
      pos += GRAN_BYTES;
    end
    if (tail != stop) return granule_short(tail / GRAN_BYTES, 0, stop - tail);
    return 1'b0;
  endfunction

  function automatic bit mark_region(int unsigned start, int unsigned n,
                                     logic [BYTE_W-1:0] fill);
    int unsigned pos;
    int unsigned tail;
    if (n == 0) return 1'b0;
    pos  = start;
    tail = (start + n) & ~GRAN_MASK;
    if ((pos & GRAN_MASK) != 0) begin
      // A region that ends inside its unaligned head granule is left alone.
      if (n < GRAN_BYTES - (pos & GRAN_MASK)) return 1'b0;
      shadow_mirror[(pos / GRAN_BYTES) % SHADOW_DEPTH] = BYTE_W'(pos & GRAN_MASK);
      pos = pos - (pos & GRAN_MASK) + GRAN_BYTES;
    end
    while (pos < tail) begin
      shadow_mirror[(pos / GRAN_BYTES) % SHADOW_DEPTH] = fill;
      pos += GRAN_BYTES;
    end
    return 1'b1;
  endfunction

  function automatic void clear_region(int unsigned start, int unsigned n);
    int unsigned last;
    if (n == 0) return;
    last = (start + n - 1) / GRAN_BYTES;
    for (int unsigned g = start / GRAN_BYTES; g <= last; g++)
      shadow_mirror[g % SHADOW_DEPTH] = '0;
  endfunction

  function automatic outcome_t apply_request(logic [KIND_W-1:0] kind,
                                             logic [ADDR_W-1:0] addr,
                                             logic [LEN_W-1:0] length,
                                             logic [BYTE_W-1:0] pb,
                                             logic nd);
    outcome_t o;
    int unsigned a;
    int unsigned n;
    bit outside;
    o = '0;
    a = addr;
    n = length;
    outside = (a + n) > WINDOW_BYTES;
    case (kind)
      K_HOOK_CHECK, K_CHECK: begin
        // A hooked check is skipped entirely while checking is disabled.
        if (!(kind == K_HOOK_CHECK && disabled_mirror)) begin
          if (outside) o.range_error = 1'b1;
          else o.poisoned = region_poisoned(a, n);
        end
      end
      K_POISON, K_USER_POISON: begin
        if (outside) o.range_error = 1'b1;
        else o.applied = mark_region(a, n, (kind == K_POISON) ? pb : user_poison_mirror);
      end
      K_UNPOISON: begin
        if (outside) begin
          o.range_error = 1'b1;
        end else begin
          clear_region(a, n);
          o.applied = 1'b1;
        end
      end
      K_SWAP: begin
        o.old_disabled  = disabled_mirror;
        disabled_mirror = nd;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int g = 0; g < SHADOW_DEPTH; g++) shadow_mirror[g] = '0;
      disabled_mirror    = 1'b0;
      user_poison_mirror = 8'd247;
      awaited_outcomes.delete();
      rsp_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.poisoned, rsp.applied, rsp.old_disabled, rsp.range_error};
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("response arrived with no request waiting");
        end else begin
          want = awaited_outcomes.pop_front();
          compare_field("poisoned", got.poisoned, want.poisoned);
          compare_field("applied", got.applied, want.applied);
          compare_field("old_disabled", got.old_disabled, want.old_disabled);
          compare_field("range_error", got.range_error, want.range_error);
        end
        rsp_seen++;
      end
      if (cfg.valid && cfg.ready) user_poison_mirror = cfg.data;
      if (req.valid && req.ready)
        awaited_outcomes.push_back(apply_request(req.kind, req.addr, req.length,
                                                 req.fill_byte, req.new_disabled));
    end
    pending <= awaited_outcomes.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the shadow memory poison checker with a directed opening and then
// random check, poison, unpoison, swap and spare-kind requests over several user poison
// settings, with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import smpc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int PHASES         = 5;
  localparam int PHASE_REQUESTS = 280;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   awaiting;
  int   cycle_count;
  int   tx_calm;
  bit   long_hold_ask;
  int unsigned hot_base;

  smpc_req_if req_ch ();
  smpc_rsp_if rsp_ch ();
  smpc_cfg_if cfg_ch ();

  shadow_memory_poison_checker dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  smpc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (mismatch_count),
    .pending    (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shadow_memory_poison_checker test failed");
      $finish;
    end
  end

  // Idle cycles before the next request or response: mostly none or short, a few long,
  // and none at all during a calm stretch.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Response side: stalls at random, with calm stretches and, on request,
  // one long hold-off that lets the block back up into its request channel.
  initial begin
    int unsigned stall;
    int unsigned calm;
    stall = 0;
    calm  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_ask) begin
        long_hold_ask = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 300);
        else if ($urandom_range(0, 99) < 40) stall = idle_cycles();
      end
    end
  end

  task automatic issue(input logic [KIND_W-1:0] k, input int unsigned a,
                       input int unsigned n, input logic [BYTE_W-1:0] pb,
                       input logic nd);
    int unsigned gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(20, 80);
      gap = idle_cycles();
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.kind         <= k;
    req_ch.addr         <= ADDR_W'(a);
    req_ch.length       <= LEN_W'(n);
    req_ch.fill_byte    <= pb;
    req_ch.new_disabled <= nd;
    req_ch.valid        <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every response has come back.
  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_poison_value(input logic [BYTE_W-1:0] v);
    settle_idle();
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 80) return $urandom_range(1, 40);
    if (r < 97) return $urandom_range(41, 600);
    if (r < 99) return $urandom_range(601, 32768);
    return $urandom_range(32769, 65535);
  endfunction

  function automatic int unsigned pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return hot_base + $urandom_range(0, 1023);
    if (r < 85) return WINDOW_BYTES - $urandom_range(1, 64);
    return $urandom_range(0, WINDOW_BYTES - 1);
  endfunction

  task automatic random_request();
    int unsigned r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 24) k = K_HOOK_CHECK;
    else if (r < 44) k = K_CHECK;
    else if (r < 60) k = K_POISON;
    else if (r < 70) k = K_USER_POISON;
    else if (r < 86) k = K_UNPOISON;
    else if (r < 94) k = K_SWAP;
    else k = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    issue(k, pick_addr(), pick_length(), BYTE_W'($urandom),
          $urandom_range(0, 2) == 0);
  endtask

  initial begin
    logic [BYTE_W-1:0] setting;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= K_HOOK_CHECK;
    req_ch.addr         <= '0;
    req_ch.length       <= '0;
    req_ch.fill_byte    <= '0;
    req_ch.new_disabled <= 1'b0;
    rsp_ch.ready        <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    tx_calm       = 0;
    long_hold_ask = 1'b0;
    hot_base      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed opening, with the user poison value still at its reset value.
    issue(K_HOOK_CHECK, 0, 0, 8'h00, 1'b0);
    issue(K_CHECK, 0, 8, 8'h00, 1'b0);
    issue(K_POISON, 3, 2, 8'hFF, 1'b0);
    issue(K_POISON, 3, 13, 8'hFF, 1'b0);
    issue(K_CHECK, 0, 3, 8'h00, 1'b0);
    issue(K_HOOK_CHECK, 2, 2, 8'h00, 1'b0);
    issue(K_CHECK, 8, 1, 8'h00, 1'b0);
    issue(K_USER_POISON, 64, 16, 8'h00, 1'b0);
    issue(K_CHECK, 60, 8, 8'h00, 1'b0);
    // A positive shadow byte of eight or more acts as a partial count.
    issue(K_POISON, 128, 8, 8'h0A, 1'b0);
    issue(K_CHECK, 128, 8, 8'h00, 1'b0);
    issue(K_POISON, 136, 8, 8'h05, 1'b0);
    issue(K_HOOK_CHECK, 136, 6, 8'h00, 1'b0);
    issue(K_HOOK_CHECK, 136, 5, 8'h00, 1'b0);
    issue(K_SWAP, 0, 0, 8'h00, 1'b1);
    issue(K_HOOK_CHECK, 8, 1, 8'h00, 1'b0);
    issue(K_HOOK_CHECK, 32767, 2, 8'h00, 1'b0);
    issue(K_CHECK, 8, 1, 8'h00, 1'b0);
    issue(K_SWAP, 0, 0, 8'h00, 1'b0);
    issue(K_CHECK, 32767, 2, 8'h00, 1'b0);
    // Unpoison must clear the tail granule that holds the last byte.
    issue(K_UNPOISON, 7, 2, 8'h00, 1'b0);
    issue(K_CHECK, 0, 16, 8'h00, 1'b0);
    issue(K_UNPOISON, 100, 0, 8'h00, 1'b0);
    issue(K_POISON, 32767, 1, 8'h80, 1'b0);
    issue(K_CHECK, 32760, 8, 8'h00, 1'b0);
    issue(KIND_SPARE_LO, 5, 9, 8'h33, 1'b1);
    issue(KIND_SPARE_HI, 32767, 65535, 8'hCC, 1'b1);
    issue(K_CHECK, 0, 32768, 8'h00, 1'b0);
    issue(K_UNPOISON, 32767, 65535, 8'h00, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: setting = 8'h00;
        1: setting = 8'hFF;
        3: setting = 8'h80;
        default: setting = BYTE_W'($urandom);
      endcase
      write_poison_value(setting);
      hot_base = $urandom_range(0, 31) * 1024;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (phase == 1 && i == 60) begin
          // Hold the response side off while requests keep coming back to back.
          long_hold_ask = 1'b1;
          tx_calm = 40;
        end
        if (phase == 2 && i == 150) settle_idle();
        random_request();
      end
    end

    settle_idle();
    repeat (30) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("shadow_memory_poison_checker test passed");
    end else begin
      $display("shadow_memory_poison_checker test failed");
    end
    $finish;
  end

endmodule

FILE: shadow_memory_poison_checker.f
src/smpc_pkg.sv
src/smpc_if.sv
src/smpc_dp.sv
src/smpc_ctrl.sv
src/shadow_memory_poison_checker.sv
tb/sv/smpc_checker.sv
tb/sv/testbench.sv
